// ===== hw/rtl/x86alu_pkg.sv =====
// Shared types, register codes and helper functions for the x86 ALU block.
package x86alu_pkg;

   // Operation codes
   localparam logic [1:0] FUNC_MOV = 2'd0;
   localparam logic [1:0] FUNC_ADD = 2'd1;
   localparam logic [1:0] FUNC_SUB = 2'd2;
   localparam logic [1:0] FUNC_CMP = 2'd3;

   // Register codes
   localparam logic [4:0] REG_AL = 5'd0;
   localparam logic [4:0] REG_AH = 5'd1;
   localparam logic [4:0] REG_AX = 5'd2;
   localparam logic [4:0] REG_CL = 5'd3;
   localparam logic [4:0] REG_CH = 5'd4;
   localparam logic [4:0] REG_CX = 5'd5;
   localparam logic [4:0] REG_DL = 5'd6;
   localparam logic [4:0] REG_DH = 5'd7;
   localparam logic [4:0] REG_DX = 5'd8;
   localparam logic [4:0] REG_BL = 5'd9;
   localparam logic [4:0] REG_BH = 5'd10;
   localparam logic [4:0] REG_BX = 5'd11;
   localparam logic [4:0] REG_SP = 5'd12;
   localparam logic [4:0] REG_BP = 5'd13;
   localparam logic [4:0] REG_SI = 5'd14;
   localparam logic [4:0] REG_DI = 5'd15;
   localparam logic [4:0] REG_ES = 5'd16;
   localparam logic [4:0] REG_CS = 5'd17;
   localparam logic [4:0] REG_SS = 5'd18;
   localparam logic [4:0] REG_DS = 5'd19;

   // Bit positions in the status flag register
   localparam int FLAG_CF = 0;
   localparam int FLAG_PF = 1;
   localparam int FLAG_AF = 2;
   localparam int FLAG_ZF = 3;
   localparam int FLAG_SF = 4;
   localparam int FLAG_OF = 5;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef logic [4:0] reg_code_type;
   // Byte file order: AL, AH, CL, CH, DL, DH, BL, BH
   typedef logic [7:0][7:0] byte_file_type;
   // Word file order: SP, BP, SI, DI, ES, CS, SS, DS
   typedef logic [7:0][15:0] word_file_type;
   typedef logic [5:0] flags_type;

   // Read a register at its own width, zero-extended; unknown codes read as zero
   function automatic logic [15:0] reg_read(input reg_code_type code,
                                            input byte_file_type bytes,
                                            input word_file_type words);
      logic [15:0] val;
      val = 16'h0000;
      case (code)
         REG_AL:  val = {8'h00, bytes[0]};
         REG_AH:  val = {8'h00, bytes[1]};
         REG_AX:  val = {bytes[1], bytes[0]};
         REG_CL:  val = {8'h00, bytes[2]};
         REG_CH:  val = {8'h00, bytes[3]};
         REG_CX:  val = {bytes[3], bytes[2]};
         REG_DL:  val = {8'h00, bytes[4]};
         REG_DH:  val = {8'h00, bytes[5]};
         REG_DX:  val = {bytes[5], bytes[4]};
         REG_BL:  val = {8'h00, bytes[6]};
         REG_BH:  val = {8'h00, bytes[7]};
         REG_BX:  val = {bytes[7], bytes[6]};
         REG_SP:  val = words[0];
         REG_BP:  val = words[1];
         REG_SI:  val = words[2];
         REG_DI:  val = words[3];
         REG_ES:  val = words[4];
         REG_CS:  val = words[5];
         REG_SS:  val = words[6];
         REG_DS:  val = words[7];
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

   // Even parity of the low byte
   function automatic logic even_parity(input logic [7:0] v);
      return ~(^v);
   endfunction

endpackage

// ===== hw/rtl/x86_16_regfile_alu_flags.sv =====
// Top level: register file, ALU and flags for MOV/ADD/SUB/CMP on 16-bit x86 registers.
//
// Usage
//   req_* carries one decoded instruction per transfer; rsp_* returns one result per
//   instruction, in order. There are no configuration registers.
//   An accepted instruction lands in an input register. On the next edge at which the
//   result register is free (or being emptied) it executes: the register file is read,
//   the add/subtract and flag logic runs, the destination and flags are written back,
//   and the result is captured in the result register, which drives rsp_tvalid.
//   Throughput is one instruction per cycle while rsp_tready stays high; the register
//   read, adder and write-back loop sets this, and back-to-back instructions see each
//   other's writes. If the receiver holds rsp_tready low, the result register holds,
//   the input register still takes one more instruction, and then req_tready drops.
//   Reset clears all general, pointer, index and segment registers, the flags and
//   both valid bits.
module x86_16_regfile_alu_flags
   import x86alu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // func[1:0], wide[2], dst_reg[7:3], src_is_imm[8], src_reg[13:9],
   // imm_value[29:14], zero[31:30]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // dst_before[15:0], result[31:16], written[32], carry_flag[33],
   // parity_flag[34], aux_flag[35], zero_flag[36], sign_flag[37],
   // overflow_flag[38], zero[39]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Input register
   logic         s1_valid_ff, s1_valid_in;
   logic [1:0]   func_ff;
   logic         wide_ff;
   reg_code_type dst_ff;
   logic         src_is_imm_ff;
   reg_code_type src_ff;
   logic [15:0]  imm_ff;

   // Architectural state
   byte_file_type bytes_ff, bytes_in;
   word_file_type words_ff, words_in;
   flags_type     flags_ff, flags_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic req_xfer;
   logic exec;

   // Execute datapath
   logic [15:0] dst_prev;
   logic [15:0] mask;
   logic [15:0] top;
   logic [15:0] opa;
   logic [15:0] opb;
   logic [16:0] sum;
   logic [16:0] diff;
   logic [4:0]  nib_sum;
   logic [15:0] res;
   logic        cf, af, of;
   logic        dst_known;
   logic        written;
   logic        wr_en;

   // Handshake: advance when the result register is empty or draining
   assign exec        = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || exec;
   assign req_xfer    = req_tvalid && req_tready;
   assign s1_valid_in = req_xfer || (s1_valid_ff && !exec);

   // Operand fetch
   always_comb begin
      dst_prev = reg_read(dst_ff, bytes_ff, words_ff);
      mask     = wide_ff ? 16'hFFFF : 16'h00FF;
      top      = wide_ff ? 16'h8000 : 16'h0080;
      opa      = dst_prev & mask;
      opb      = (src_is_imm_ff ? imm_ff : reg_read(src_ff, bytes_ff, words_ff)) & mask;
   end

   // Add / subtract and flag evaluation
   always_comb begin
      sum     = {1'b0, opa} + {1'b0, opb};
      diff    = {1'b0, opa} - {1'b0, opb};
      nib_sum = {1'b0, opa[3:0]} + {1'b0, opb[3:0]};
      res     = opb;
      cf      = 1'b0;
      af      = 1'b0;
      of      = 1'b0;
      case (func_ff)
         FUNC_ADD: begin
            res = sum[15:0] & mask;
            cf  = wide_ff ? sum[16] : sum[8];
            af  = nib_sum[4];
            of  = |(~(opa ^ opb) & (opa ^ res) & top);
         end
         FUNC_SUB, FUNC_CMP: begin
            res = diff[15:0] & mask;
            cf  = opb > opa;
            af  = opa[3:0] < opb[3:0];
            of  = |((opa ^ opb) & (opa ^ res) & top);
         end
         default: begin
            res = opb;
         end
      endcase

      flags_in = flags_ff;
      if (exec && func_ff != FUNC_MOV) begin
         flags_in[FLAG_CF] = cf;
         flags_in[FLAG_PF] = even_parity(res[7:0]);
         flags_in[FLAG_AF] = af;
         flags_in[FLAG_ZF] = (res == 16'h0000);
         flags_in[FLAG_SF] = |(res & top);
         flags_in[FLAG_OF] = of;
      end
   end

   // Write-back: each register stores the result at its own width
   always_comb begin
      dst_known = dst_ff <= REG_DS;
      written   = dst_known && func_ff != FUNC_CMP;
      wr_en     = exec && written;
      bytes_in  = bytes_ff;
      words_in  = words_ff;
      if (wr_en) begin
         case (dst_ff)
            REG_AL:  bytes_in[0] = res[7:0];
            REG_AH:  bytes_in[1] = res[7:0];
            REG_AX:  {bytes_in[1], bytes_in[0]} = res;
            REG_CL:  bytes_in[2] = res[7:0];
            REG_CH:  bytes_in[3] = res[7:0];
            REG_CX:  {bytes_in[3], bytes_in[2]} = res;
            REG_DL:  bytes_in[4] = res[7:0];
            REG_DH:  bytes_in[5] = res[7:0];
            REG_DX:  {bytes_in[5], bytes_in[4]} = res;
            REG_BL:  bytes_in[6] = res[7:0];
            REG_BH:  bytes_in[7] = res[7:0];
            REG_BX:  {bytes_in[7], bytes_in[6]} = res;
            REG_SP:  words_in[0] = res;
            REG_BP:  words_in[1] = res;
            REG_SI:  words_in[2] = res;
            REG_DI:  words_in[3] = res;
            REG_ES:  words_in[4] = res;
            REG_CS:  words_in[5] = res;
            REG_SS:  words_in[6] = res;
            REG_DS:  words_in[7] = res;
            default: begin
               bytes_in = bytes_ff;
            end
         endcase
      end
   end

   // Result register next state
   always_comb begin
      rsp_valid_in = exec || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (exec) begin
         rsp_data_in = {1'b0,
                        flags_in[FLAG_OF], flags_in[FLAG_SF], flags_in[FLAG_ZF],
                        flags_in[FLAG_AF], flags_in[FLAG_PF], flags_in[FLAG_CF],
                        written, res, dst_prev};
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bytes_ff     <= '0;
         words_ff     <= '0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bytes_ff     <= bytes_in;
         words_ff     <= words_in;
         flags_ff     <= flags_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         func_ff       <= req_tdata[1:0];
         wide_ff       <= req_tdata[2];
         dst_ff        <= req_tdata[7:3];
         src_is_imm_ff <= req_tdata[8];
         src_ff        <= req_tdata[13:9];
         imm_ff        <= req_tdata[29:14];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== tb/sv/x86alu_flag_checker.sv =====
// Checker for the x86 ALU block: predicts each instruction's outcome and compares the responses.
`timescale 1ns / 100ps

module x86alu_flag_checker
   import x86alu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    pending
);

   // Response fields, top bit first, so that a cast of rsp_tdata[38:0] unpacks them
   typedef struct packed {
      logic        of;
      logic        sf;
      logic        zf;
      logic        af;
      logic        pf;
      logic        cf;
      logic        written;
      logic [15:0] result;
      logic [15:0] dst_before;
   } alu_outcome_type;

   // Predicted architectural state
   byte_file_type byte_regs;   // AL, AH, CL, CH, DL, DH, BL, BH
   word_file_type word_regs;   // SP, BP, SI, DI, ES, CS, SS, DS
   flags_type     status;

   alu_outcome_type expected_outcomes[$];
   int              fails;

   // Register value at its own width, zero-extended; unknown codes give zero
   function automatic logic [15:0] fetch_reg(input reg_code_type code);
      logic [15:0] v;
      v = 16'h0000;
      case (code)
         REG_AL: v[7:0] = byte_regs[0];
         REG_AH: v[7:0] = byte_regs[1];
         REG_AX: v      = {byte_regs[1], byte_regs[0]};
         REG_CL: v[7:0] = byte_regs[2];
         REG_CH: v[7:0] = byte_regs[3];
         REG_CX: v      = {byte_regs[3], byte_regs[2]};
         REG_DL: v[7:0] = byte_regs[4];
         REG_DH: v[7:0] = byte_regs[5];
         REG_DX: v      = {byte_regs[5], byte_regs[4]};
         REG_BL: v[7:0] = byte_regs[6];
         REG_BH: v[7:0] = byte_regs[7];
         REG_BX: v      = {byte_regs[7], byte_regs[6]};
         REG_SP, REG_BP, REG_SI, REG_DI,
         REG_ES, REG_CS, REG_SS, REG_DS: v = word_regs[3'(code - REG_SP)];
         default: v = 16'h0000;
      endcase
      return v;
   endfunction

   // Write at the register's own width; returns 0 when the code names no register
   function automatic logic store_reg(input reg_code_type code, input logic [15:0] v);
      logic done;
      done = 1'b1;
      case (code)
         REG_AL: byte_regs[0] = v[7:0];
         REG_AH: byte_regs[1] = v[7:0];
         REG_AX: {byte_regs[1], byte_regs[0]} = v;
         REG_CL: byte_regs[2] = v[7:0];
         REG_CH: byte_regs[3] = v[7:0];
         REG_CX: {byte_regs[3], byte_regs[2]} = v;
         REG_DL: byte_regs[4] = v[7:0];
         REG_DH: byte_regs[5] = v[7:0];
         REG_DX: {byte_regs[5], byte_regs[4]} = v;
         REG_BL: byte_regs[6] = v[7:0];
         REG_BH: byte_regs[7] = v[7:0];
         REG_BX: {byte_regs[7], byte_regs[6]} = v;
         REG_SP, REG_BP, REG_SI, REG_DI,
         REG_ES, REG_CS, REG_SS, REG_DS: word_regs[3'(code - REG_SP)] = v;
         default: done = 1'b0;
      endcase
      return done;
   endfunction

   // Run one instruction on the predicted state and return what the block should report
   function automatic alu_outcome_type execute_instr(input logic [REQ_DATA_W-1:0] word);
      logic [1:0]      func;
      logic            wide;
      logic            src_imm;
      reg_code_type    dst;
      reg_code_type    src;
      logic [15:0]     imm;
      logic [15:0]     mask;
      logic [15:0]     top;
      logic [15:0]     a;
      logic [15:0]     b;
      logic [15:0]     res;
      logic [16:0]     sum;
      logic [4:0]      nib_sum;
      alu_outcome_type o;

      func    = word[1:0];
      wide    = word[2];
      dst     = word[7:3];
      src_imm = word[8];
      src     = word[13:9];
      imm     = word[29:14];

      mask = wide ? 16'hFFFF : 16'h00FF;
      top  = wide ? 16'h8000 : 16'h0080;
      o    = '0;
      o.dst_before = fetch_reg(dst);
      a = o.dst_before & mask;
      b = (src_imm ? imm : fetch_reg(src)) & mask;

      if (func == FUNC_MOV) begin
         res       = b;
         o.written = store_reg(dst, res);
      end else begin
         if (func == FUNC_ADD) begin
            sum     = {1'b0, a} + {1'b0, b};
            nib_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]};
            res     = sum[15:0] & mask;
            status[FLAG_CF] = wide ? sum[16] : sum[8];
            status[FLAG_AF] = nib_sum[4];
            status[FLAG_OF] = ((~(a ^ b)) & (a ^ res) & top) != 16'h0000;
         end else begin
            // sub and cmp share the borrow logic
            res = (a - b) & mask;
            status[FLAG_CF] = b > a;
            status[FLAG_AF] = a[3:0] < b[3:0];
            status[FLAG_OF] = ((a ^ b) & (a ^ res) & top) != 16'h0000;
         end
         status[FLAG_PF] = ~(^res[7:0]);
         status[FLAG_ZF] = res == 16'h0000;
         status[FLAG_SF] = (res & top) != 16'h0000;
         if (func != FUNC_CMP) o.written = store_reg(dst, res);
      end

      o.result = res;
      o.cf = status[FLAG_CF];
      o.pf = status[FLAG_PF];
      o.af = status[FLAG_AF];
      o.zf = status[FLAG_ZF];
      o.sf = status[FLAG_SF];
      o.of = status[FLAG_OF];
      return o;
   endfunction

   // Watch both channels; responses are checked before the same edge's request is predicted
   always @(posedge clock) begin
      alu_outcome_type got;
      alu_outcome_type exp;
      if (reset) begin
         byte_regs = '0;
         word_regs = '0;
         status    = '0;
         expected_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = alu_outcome_type'(rsp_tdata[38:0]);
            if (expected_outcomes.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: response with nothing outstanding: %h", $time, rsp_tdata);
            end else begin
               exp = expected_outcomes.pop_front();
               if (got.dst_before !== exp.dst_before || got.result !== exp.result ||
                   got.written !== exp.written || got.cf !== exp.cf || got.pf !== exp.pf ||
                   got.af !== exp.af || got.zf !== exp.zf || got.sf !== exp.sf ||
                   got.of !== exp.of) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: mismatch, expected before=%h res=%h wr=%b c/p/a/z/s/o=%b%b%b%b%b%b",
                              $time, exp.dst_before, exp.result, exp.written,
                              exp.cf, exp.pf, exp.af, exp.zf, exp.sf, exp.of);
                     $display("%0t:           actual   before=%h res=%h wr=%b c/p/a/z/s/o=%b%b%b%b%b%b",
                              $time, got.dst_before, got.result, got.written,
                              got.cf, got.pf, got.af, got.zf, got.sf, got.of);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(execute_instr(req_tdata));
      end
      pending    <= expected_outcomes.size();
      fail_count <= fails;
   end

endmodule

// ===== tb/sv/tb_x86_16_regfile_alu_flags.sv =====
// Testbench top for the x86 ALU block: clock, reset, instruction stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_x86_16_regfile_alu_flags;
   import x86alu_pkg::*;

   // Codes that name no register
   localparam reg_code_type REG_NONE_LO = 5'd20;
   localparam reg_code_type REG_NONE_HI = 5'd31;

   localparam int RANDOM_PER_PHASE = 460;
   localparam int HOLD_AFTER_ITEMS = 300;
   localparam int HOLD_CYCLES      = 80;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // func, wide, dst_reg, src_is_imm, src_reg, imm_value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // dst_before, result, written, flags

   int fail_count;
   int pending;
   int send_idle_pct = 7;
   int rsp_idle_pct  = 58;
   int items_sent    = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   always #5 clock = ~clock;

   x86_16_regfile_alu_flags u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   x86alu_flag_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Offer one instruction after a random gap and wait for its transfer
   task automatic send_instr(input logic [1:0] func, input logic wide, input reg_code_type dst,
                             input logic src_imm, input reg_code_type src,
                             input logic [15:0] imm);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, imm, src, src_imm, dst, wide, func};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Mostly real registers, now and then a code that names none
   function automatic reg_code_type pick_reg();
      if ($urandom_range(99) < 12)
         return reg_code_type'($urandom_range(REG_NONE_HI, REG_NONE_LO));
      return reg_code_type'($urandom_range(REG_DS, REG_AL));
   endfunction

   // Immediates biased towards sign and carry boundaries
   function automatic logic [15:0] pick_imm();
      logic [15:0] corners[8];
      corners = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h007F, 16'h0080, 16'h00FF, 16'h000F};
      case ($urandom_range(3))
         0, 1:    return 16'($urandom_range(16'hFFFF));
         2:       return corners[$urandom_range(7)];
         default: return 16'($urandom_range(16'h00FF));
      endcase
   endfunction

   // Receiver: random stalls, plus one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && items_sent >= HOLD_AFTER_ITEMS) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Stimulus and verdict
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: carries, borrows, overflows, width mismatches, unknown codes
      send_instr(FUNC_MOV, 1'b1, REG_AX, 1'b1, REG_AL, 16'hFFFF);
      send_instr(FUNC_ADD, 1'b0, REG_AL, 1'b1, REG_AL, 16'h0001);
      send_instr(FUNC_ADD, 1'b0, REG_AH, 1'b1, REG_AL, 16'h0080);
      send_instr(FUNC_MOV, 1'b0, REG_BL, 1'b1, REG_AL, 16'h007F);
      send_instr(FUNC_ADD, 1'b0, REG_BL, 1'b1, REG_AL, 16'h0001);
      send_instr(FUNC_SUB, 1'b0, REG_CL, 1'b0, REG_BL, 16'h0000);
      send_instr(FUNC_SUB, 1'b1, REG_SP, 1'b1, REG_AL, 16'h0001);
      send_instr(FUNC_CMP, 1'b1, REG_AX, 1'b0, REG_AX, 16'h0000);
      send_instr(FUNC_CMP, 1'b1, REG_DX, 1'b1, REG_AL, 16'h8000);
      send_instr(FUNC_MOV, 1'b1, REG_DS, 1'b0, REG_AX, 16'h0000);
      send_instr(FUNC_ADD, 1'b1, REG_AL, 1'b1, REG_AL, 16'h1234);
      send_instr(FUNC_MOV, 1'b0, REG_SI, 1'b1, REG_AL, 16'hABCD);
      send_instr(FUNC_ADD, 1'b1, REG_SI, 1'b1, REG_AL, 16'hFFFF);
      send_instr(FUNC_MOV, 1'b1, REG_NONE_HI, 1'b1, REG_AL, 16'h5A5A);
      send_instr(FUNC_ADD, 1'b1, REG_NONE_LO, 1'b1, REG_AL, 16'hFFFF);
      send_instr(FUNC_MOV, 1'b0, REG_DH, 1'b0, REG_NONE_HI, 16'hFFFF);
      send_instr(FUNC_SUB, 1'b0, REG_DH, 1'b0, REG_DH, 16'h0000);
      send_instr(FUNC_ADD, 1'b0, REG_CX, 1'b0, REG_BH, 16'h0000);
      send_instr(FUNC_ADD, 1'b1, REG_ES, 1'b1, REG_AL, 16'h8000);
      send_instr(FUNC_ADD, 1'b1, REG_ES, 1'b1, REG_AL, 16'h8000);
      send_instr(FUNC_MOV, 1'b1, REG_BP, 1'b1, REG_AL, 16'h0000);
      send_instr(FUNC_CMP, 1'b0, REG_BP, 1'b1, REG_AL, 16'hFFFF);
      send_instr(FUNC_SUB, 1'b1, REG_DI, 1'b0, REG_CS, 16'h0000);
      send_instr(FUNC_MOV, 1'b1, REG_CS, 1'b0, REG_SI, 16'h0000);
      send_instr(FUNC_SUB, 1'b1, REG_SS, 1'b0, REG_DS, 16'h0000);

      // Random: sender light/receiver heavy, then reversed, then no idling
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               rsp_idle_pct  = 58;
            end
            1: begin
               send_idle_pct = 58;
               rsp_idle_pct  = 7;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_instr(2'($urandom_range(3)), 1'($urandom_range(1)), pick_reg(),
                       1'($urandom_range(1)), pick_reg(), pick_imm());
      end
      req_tvalid <= 1'b0;

      // Drain, then allow for the pipeline depth
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
